### sv/png_scanline_defilter_defines.svh
// Assertion macros used by the checker file of the scanline defilter.
`ifndef PNG_SCANLINE_DEFILTER_DEFINES_SVH
`define PNG_SCANLINE_DEFILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PNGDF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PNGDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pngdf_pkg.sv
// Package with widths, register and filter codes and the Paeth predictor.
package pngdf_pkg;

    localparam int BYTE_W        = 8;
    localparam int ROW_BYTES_W   = 14;
    localparam int PIXEL_BYTES_W = 4;
    localparam int FILTER_W      = 3;
    localparam int APB_DATA_W    = 32;
    localparam int PADDR_W       = 3;
    localparam int REG_SEL_BIT   = 2;

    localparam int DEF_MAX_ROW_BYTES   = 8192;
    localparam int DEF_MAX_PIXEL_BYTES = 8;

    // Register index codes, taken from paddr[REG_SEL_BIT].
    localparam logic REG_ROW_BYTES   = 1'b0;
    localparam logic REG_PIXEL_BYTES = 1'b1;

    // Filter type codes.
    localparam logic [FILTER_W-1:0] FILT_NONE  = 3'd0;
    localparam logic [FILTER_W-1:0] FILT_SUB   = 3'd1;
    localparam logic [FILTER_W-1:0] FILT_UP    = 3'd2;
    localparam logic [FILTER_W-1:0] FILT_AVG   = 3'd3;
    localparam logic [FILTER_W-1:0] FILT_PAETH = 3'd4;

    typedef logic [BYTE_W-1:0] byte_t;

    // Paeth predictor: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|.
    function automatic byte_t paeth_pick(input byte_t a, input byte_t b, input byte_t c);
        byte_t       pa;
        byte_t       pb;
        logic [9:0]  sum_ab;
        logic [9:0]  twice_c;
        logic [9:0]  pc;
        byte_t       pick;
        pa      = (b > c) ? (b - c) : (c - b);
        pb      = (a > c) ? (a - c) : (c - a);
        sum_ab  = {2'b00, a} + {2'b00, b};
        twice_c = {1'b0, c, 1'b0};
        pc      = (sum_ab > twice_c) ? (sum_ab - twice_c) : (twice_c - sum_ab);
        if ((pa <= pb) && ({2'b00, pa} <= pc))
        begin
            pick = a;
        end
        else if ({2'b00, pb} <= pc)
        begin
            pick = b;
        end
        else
        begin
            pick = c;
        end
        return pick;
    endfunction

endpackage

### sv/pngdf_in_if.sv
// Input channel: stream bytes with the image start mark.
interface pngdf_in_if
    import pngdf_pkg::*;
();
    logic        valid;
    logic        ready;
    byte_t       data_byte;
    logic        image_start;

    modport source (output valid, output data_byte, output image_start, input ready);
    modport sink (input valid, input data_byte, input image_start, output ready);
endinterface

### sv/pngdf_out_if.sv
// Output channel: reconstructed bytes with row end and error flags.
interface pngdf_out_if
    import pngdf_pkg::*;
();
    logic        valid;
    logic        ready;
    byte_t       pixel_byte;
    logic        row_end;
    logic        filter_error;

    modport source (output valid, output pixel_byte, output row_end, output filter_error,
                    input ready);
    modport sink (input valid, input pixel_byte, input row_end, input filter_error,
                  output ready);
endinterface

### sv/pngdf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pngdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/png_scanline_defilter.sv
// Order: an accepted item enters the input register; once the result register is free or being
// drained, the filter stage computes the answer and the result register takes it.
// Throughput: one item per cycle unless the output stalls; the filter logic is one stage,
// and the row store read is issued one column ahead so the byte above is ready in that stage.
// Reset (rst_n low, asynchronous) clears the row state, both histories and the handshakes,
// and sets row_bytes and pixel_bytes to 1. The row store is not cleared and needs no pass.
module png_scanline_defilter
    import pngdf_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = DEF_MAX_ROW_BYTES,
    parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    pngdf_in_if.sink               stream_in,
    pngdf_out_if.source            pixel_out,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);
    localparam int AW = $clog2(MAX_ROW_BYTES);
    localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int CW = ((AW > ROW_BYTES_W) ? AW : ROW_BYTES_W) + 1;

    // Configuration
    logic [ROW_BYTES_W-1:0]   row_bytes_reg;
    logic [PIXEL_BYTES_W-1:0] pixel_bytes_reg;
    logic [ROW_BYTES_W-1:0]   row_wr_value;
    logic [PIXEL_BYTES_W-1:0] pix_wr_value;
    logic                     cfg_wr;

    // Input and result stages
    logic        in_v_reg, in_v_next;
    byte_t       in_byte_reg;
    logic        in_start_reg;
    logic        out_v_reg, out_v_next;
    byte_t       out_pix_reg, out_pix_next;
    logic        out_end_reg, out_end_next;
    logic        out_err_reg, out_err_next;
    logic        advance;
    logic        produce;

    // Row state
    logic [AW-1:0]        col_reg, col_next;
    logic [FILTER_W-1:0]  kind_reg, kind_next;
    logic                 awaiting_reg, awaiting_next;
    logic                 first_reg, first_next;
    logic                 stuck_reg, stuck_next;
    byte_t                left_hist_reg [MAX_PIXEL_BYTES];
    byte_t                left_hist_next [MAX_PIXEL_BYTES];
    byte_t                ul_hist_reg [MAX_PIXEL_BYTES];
    byte_t                ul_hist_next [MAX_PIXEL_BYTES];
    // Entry k counts the column modulo k+1, so any pixel_bytes picks its slot directly.
    logic [SW-1:0]        mod_cnt_reg [MAX_PIXEL_BYTES];
    logic [SW-1:0]        mod_cnt_next [MAX_PIXEL_BYTES];

    // Row store and its bypass for a write and read of the same column at one edge
    logic                 mem_we;
    byte_t                mem_rdata;
    logic                 byp_v_reg, byp_v_next;
    byte_t                byp_d_reg;

    // Datapath
    logic                 filter_path;
    logic                 data_path;
    logic                 bad_filter;
    logic [SW-1:0]        slot;
    logic                 margin;
    logic                 last_col;
    byte_t                a_val, b_val, c_val, b_raw, pred, rebuilt;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        row_wr_value = pwdata[ROW_BYTES_W-1:0];
        if (row_wr_value == '0)
        begin
            row_wr_value = ROW_BYTES_W'(1);
        end
        else if (CW'(row_wr_value) > CW'(MAX_ROW_BYTES))
        begin
            row_wr_value = ROW_BYTES_W'(MAX_ROW_BYTES);
        end

        pix_wr_value = pwdata[PIXEL_BYTES_W-1:0];
        if (pix_wr_value == '0)
        begin
            pix_wr_value = PIXEL_BYTES_W'(1);
        end
        else if (pix_wr_value > PIXEL_BYTES_W'(MAX_PIXEL_BYTES))
        begin
            pix_wr_value = PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg   <= ROW_BYTES_W'(1);
            pixel_bytes_reg <= PIXEL_BYTES_W'(1);
        end
        else if (cfg_wr)
        begin
            case (paddr[REG_SEL_BIT])
                REG_ROW_BYTES:   row_bytes_reg   <= row_wr_value;
                REG_PIXEL_BYTES: pixel_bytes_reg <= pix_wr_value;
                default:         row_bytes_reg   <= row_bytes_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[REG_SEL_BIT])
            REG_ROW_BYTES:   prdata = APB_DATA_W'(row_bytes_reg);
            REG_PIXEL_BYTES: prdata = APB_DATA_W'(pixel_bytes_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------- handshakes ----------------
    assign advance         = in_v_reg && (!out_v_reg || pixel_out.ready);
    assign stream_in.ready = !in_v_reg || advance;

    always_comb
    begin
        if (stream_in.valid && stream_in.ready)
        begin
            in_v_next = 1'b1;
        end
        else if (advance)
        begin
            in_v_next = 1'b0;
        end
        else
        begin
            in_v_next = in_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream_in.valid && stream_in.ready)
        begin
            in_byte_reg  <= stream_in.data_byte;
            in_start_reg <= stream_in.image_start;
        end
    end

    // ---------------- reconstruction ----------------
    // An image start forces the byte to be a filter byte, whatever the row state says.
    assign filter_path = in_start_reg || (!stuck_reg && awaiting_reg);
    assign data_path   = !in_start_reg && !stuck_reg && !awaiting_reg;
    assign bad_filter  = in_byte_reg > BYTE_W'(FILT_PAETH);

    assign slot     = mod_cnt_reg[SW'(pixel_bytes_reg - PIXEL_BYTES_W'(1))];
    assign margin   = CW'(col_reg) < CW'(pixel_bytes_reg);
    assign last_col = (CW'(col_reg) + CW'(1)) >= CW'(row_bytes_reg);

    assign b_raw = byp_v_reg ? byp_d_reg : mem_rdata;
    assign a_val = margin ? '0 : left_hist_reg[slot];
    assign b_val = first_reg ? '0 : b_raw;
    assign c_val = (first_reg || margin) ? '0 : ul_hist_reg[slot];

    always_comb
    begin
        case (kind_reg)
            FILT_SUB:   pred = a_val;
            FILT_UP:    pred = b_val;
            FILT_AVG:   pred = BYTE_W'(({1'b0, a_val} + {1'b0, b_val}) >> 1);
            FILT_PAETH: pred = paeth_pick(a_val, b_val, c_val);
            default:    pred = '0;
        endcase
    end

    assign rebuilt = in_byte_reg + pred;

    always_comb
    begin
        col_next       = col_reg;
        kind_next      = kind_reg;
        awaiting_next  = awaiting_reg;
        first_next     = first_reg;
        stuck_next     = stuck_reg;
        left_hist_next = left_hist_reg;
        ul_hist_next   = ul_hist_reg;
        mod_cnt_next   = mod_cnt_reg;
        produce        = 1'b0;
        out_pix_next   = out_pix_reg;
        out_end_next   = out_end_reg;
        out_err_next   = out_err_reg;
        mem_we         = 1'b0;

        if (advance && filter_path)
        begin
            if (in_start_reg)
            begin
                col_next       = '0;
                kind_next      = FILT_NONE;
                first_next     = 1'b1;
                left_hist_next = '{default: '0};
                ul_hist_next   = '{default: '0};
                mod_cnt_next   = '{default: '0};
            end
            if (bad_filter)
            begin
                stuck_next    = 1'b1;
                awaiting_next = 1'b1;
                produce       = 1'b1;
                out_pix_next  = '0;
                out_end_next  = 1'b0;
                out_err_next  = 1'b1;
            end
            else
            begin
                stuck_next    = 1'b0;
                awaiting_next = 1'b0;
                kind_next     = in_byte_reg[FILTER_W-1:0];
            end
        end
        else if (advance && data_path)
        begin
            mem_we             = 1'b1;
            left_hist_next[slot] = rebuilt;
            ul_hist_next[slot]   = b_val;
            produce            = 1'b1;
            out_pix_next       = rebuilt;
            out_end_next       = last_col;
            out_err_next       = 1'b0;
            if (last_col)
            begin
                col_next      = '0;
                mod_cnt_next  = '{default: '0};
                awaiting_next = 1'b1;
                first_next    = 1'b0;
            end
            else
            begin
                col_next = col_reg + AW'(1);
                for (int k = 0; k < MAX_PIXEL_BYTES; k++)
                begin
                    if (mod_cnt_reg[k] == SW'(k))
                    begin
                        mod_cnt_next[k] = '0;
                    end
                    else
                    begin
                        mod_cnt_next[k] = mod_cnt_reg[k] + SW'(1);
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (produce)
        begin
            out_v_next = 1'b1;
        end
        else if (pixel_out.ready)
        begin
            out_v_next = 1'b0;
        end
        else
        begin
            out_v_next = out_v_reg;
        end
    end

    // The read for the next column goes out now, so its data is ready with the next item.
    assign byp_v_next = mem_we && (col_next == col_reg);

    pngdf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_ROW_BYTES)
    ) u_pngdf_row_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (col_reg),
        .wdata (rebuilt),
        .raddr (col_next),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg      <= 1'b0;
            out_v_reg     <= 1'b0;
            col_reg       <= '0;
            kind_reg      <= FILT_NONE;
            awaiting_reg  <= 1'b1;
            first_reg     <= 1'b1;
            stuck_reg     <= 1'b0;
            left_hist_reg <= '{default: '0};
            ul_hist_reg   <= '{default: '0};
            mod_cnt_reg   <= '{default: '0};
            byp_v_reg     <= 1'b0;
        end
        else
        begin
            in_v_reg      <= in_v_next;
            out_v_reg     <= out_v_next;
            col_reg       <= col_next;
            kind_reg      <= kind_next;
            awaiting_reg  <= awaiting_next;
            first_reg     <= first_next;
            stuck_reg     <= stuck_next;
            left_hist_reg <= left_hist_next;
            ul_hist_reg   <= ul_hist_next;
            mod_cnt_reg   <= mod_cnt_next;
            byp_v_reg     <= byp_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pix_reg <= out_pix_next;
        out_end_reg <= out_end_next;
        out_err_reg <= out_err_next;
        byp_d_reg   <= rebuilt;
    end

    assign pixel_out.valid        = out_v_reg;
    assign pixel_out.pixel_byte   = out_pix_reg;
    assign pixel_out.row_end      = out_end_reg;
    assign pixel_out.filter_error = out_err_reg;
endmodule

### sv/pngdf_checker.sv
// Checker on the defilter's stream ports, bound to the top level.
`include "png_scanline_defilter_defines.svh"

module pngdf_checker
    import pngdf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_ready,
    input  logic  out_valid,
    input  logic  out_ready,
    input  byte_t out_pixel_byte,
    input  logic  out_row_end,
    input  logic  out_filter_error
);
    // Items accepted but not yet answered; sticks at its maximum instead of wrapping.
    logic [31:0] credit_reg, credit_next;
    logic        in_acc;
    logic        out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        credit_next = credit_reg;
        if (credit_reg != '1)
        begin
            credit_next = credit_reg + 32'(in_acc) - 32'(out_acc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    `PNGDF_ASSERT_NOW(a_error_result_clean, out_valid && out_filter_error, (out_pixel_byte == '0) && !out_row_end, "error item carries data or row end")
    `PNGDF_ASSERT_NOW(a_no_invented_result, out_valid, credit_reg != '0, "result item without an accepted input item")
    `PNGDF_ASSERT_NOW(a_ready_when_drained, !out_valid, in_ready, "input stalled while the result register is empty")
    `PNGDF_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_pixel_byte) && $stable(out_row_end) && $stable(out_filter_error), "stalled result item changed")
endmodule

bind png_scanline_defilter pngdf_checker u_pngdf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (stream_in.valid),
    .in_ready         (stream_in.ready),
    .out_valid        (pixel_out.valid),
    .out_ready        (pixel_out.ready),
    .out_pixel_byte   (pixel_out.pixel_byte),
    .out_row_end      (pixel_out.row_end),
    .out_filter_error (pixel_out.filter_error)
);
